FILE: hw/rtl/csnm_pkg.sv
// shared types, constants and chord tables for the chord strum-plate note mapper
// used by csnm_div and chord_strumplate_note_mapper_unit; no dependencies
`default_nettype none

package csnm_pkg;

	localparam int FINGER_SLOTS = 10;
	localparam int MAX_STRINGS  = 20;
	localparam int OCTAVES      = 6;

	localparam int SLOT_W  = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;
	localparam int COORD_W = 9;
	localparam int STR_W   = 5;
	localparam int NOTE_W  = 7;
	localparam int BASE_W  = 6;
	localparam int ROOT_W  = 4;
	localparam int ID_W    = 8;
	// plate offset times string count (count is at most 20, five bits)
	localparam int DVD_W   = COORD_W + STR_W;

	localparam logic [ROOT_W-1:0] ROOT_MAX = 4'd11;
	localparam logic [NOTE_W:0]   NOTE_MAX = 8'd127;

	typedef enum logic [1:0] {
		FN_CHORD = 2'd0,
		FN_TOUCH = 2'd1,
		FN_LIFT  = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_PLATE_LEFT   = 3'd0,
		REG_PLATE_WIDTH  = 3'd1,
		REG_PLATE_TOP    = 3'd2,
		REG_PLATE_HEIGHT = 3'd3,
		REG_BASE_NOTE    = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		CK_MAJOR   = 3'd0,
		CK_MINOR   = 3'd1,
		CK_SEVENTH = 3'd2,
		CK_MAJ7    = 3'd3,
		CK_M7      = 3'd4,
		CK_DIM     = 3'd5,
		CK_AUG     = 3'd6
	} chord_kind_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [ROOT_W-1:0]  root;
		logic               hold_major;
		logic               hold_minor;
		logic               hold_seventh;
		logic [ID_W-1:0]    finger_id;
		logic [COORD_W-1:0] touch_x;
		logic [COORD_W-1:0] touch_y;
	} item_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note_number;
		logic [STR_W-1:0]  string_index;
		logic              last_of_run;
	} strike_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [2:0] kind_count(chord_kind_t kind);
		logic [2:0] c;
		case (kind)
			CK_SEVENTH, CK_MAJ7, CK_M7: c = 3'd4;
			default:                    c = 3'd3;
		endcase
		return c;
	endfunction

	function automatic logic [3:0] interval(chord_kind_t kind, logic [1:0] pos);
		logic [3:0] v;
		case (pos)
			2'd0: v = 4'd0;
			2'd1: v = (kind == CK_MINOR || kind == CK_M7 || kind == CK_DIM) ? 4'd3 : 4'd4;
			2'd2: v = (kind == CK_DIM) ? 4'd6 : (kind == CK_AUG) ? 4'd8 : 4'd7;
			default: v = (kind == CK_MAJ7) ? 4'd11 :
			             (kind == CK_SEVENTH || kind == CK_M7) ? 4'd10 : 4'd0;
		endcase
		return v;
	endfunction

	function automatic logic [STR_W-1:0] string_count(chord_kind_t kind);
		int n;
		n = OCTAVES * int'(kind_count(kind));
		if (n > MAX_STRINGS) n = MAX_STRINGS;
		return STR_W'(n);
	endfunction

	// semitone offset of string k above the chord root
	function automatic logic [7:0] string_offset(chord_kind_t kind, logic [STR_W-1:0] k);
		logic [3:0] q3;
		logic [4:0] r3;
		logic [3:0] oct;
		logic [1:0] pos;
		q3 = '0;
		for (int i = 1; i <= 10; i++) begin
			if (k >= 5'(3 * i)) q3 = 4'(i);
		end
		r3 = k - 5'(5'(q3) * 5'd3);
		if (kind_count(kind) == 3'd4) begin
			oct = {1'b0, k[4:2]};
			pos = k[1:0];
		end else begin
			oct = q3;
			pos = r3[1:0];
		end
		return 8'(8'(oct) * 8'd12) + 8'(interval(kind, pos));
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/chord_strumplate_note_mapper_unit.sv
// top level of the chord strum-plate note mapper: chord state, finger slots,
// strike sequencer and output register; depends on csnm_pkg and csnm_div
//
// usage
//   item channel (item, item_valid, item_stall): one event per transfer,
//   chord select, touch sample or finger lift. item_stall is high while an
//   event is being worked on; one event is handled at a time.
//   strike channel (strike, strike_valid, strike_stall): zero or more strikes
//   per touch sample, in crossing order; last_of_run marks the final one.
//   wr_en / wr_index / wr_data write the plate and base-note registers;
//   indexes past the register list are dropped.
// timing
//   chord select, lift, ignored codes and touches that start no division
//   (off the plate, outside x, no free slot): capture, then decode, after
//   which the next item can be taken. touch on the plate: capture, decode,
//   the one-bit-a-cycle divider that maps x to a string index, then the
//   walk, one string crossed a cycle while the output register is free.
//   strings beyond the current string count are skipped one a cycle.
// reset
//   chord goes to C major, every finger slot is freed, registers take their
//   defaults, strike_valid drops.
// stall
//   a held strike keeps its payload; the walk over crossed strings pauses
//   until the output register frees, while the last strike of a run may wait
//   there as the next item is taken.
`default_nettype none

module chord_strumplate_note_mapper_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire csnm_pkg::item_t           item,
	input  wire logic                      item_valid,
	output logic                           item_stall,
	output csnm_pkg::strike_t              strike,
	output logic                           strike_valid,
	input  wire logic                      strike_stall,
	input  wire logic                      wr_en,
	input  wire logic [2:0]                wr_index,
	input  wire logic [csnm_pkg::COORD_W-1:0] wr_data
);

	localparam int SLOTS = csnm_pkg::FINGER_SLOTS;
	localparam int SW    = csnm_pkg::SLOT_W;
	localparam int XW    = csnm_pkg::COORD_W;
	localparam int STW   = csnm_pkg::STR_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIVIDE,
		ST_WALK
	} state_t;

	state_t                     state_q;
	csnm_pkg::item_t            item_q;

	// plate and note registers
	logic [XW-1:0]              plate_left_q;
	logic [XW-1:0]              plate_width_q;
	logic [XW-1:0]              plate_top_q;
	logic [XW-1:0]              plate_height_q;
	logic [csnm_pkg::BASE_W-1:0] base_note_q;

	// chord and finger slots
	logic [csnm_pkg::ROOT_W-1:0] chord_root_q;
	csnm_pkg::chord_kind_t      chord_kind_q;
	logic [SLOTS-1:0]           slot_in_use_q;
	logic [csnm_pkg::ID_W-1:0]  slot_finger_q [SLOTS];
	logic [STW-1:0]             slot_last_q   [SLOTS];
	logic [SLOTS-1:0]           slot_fresh_q;

	// run registers
	logic [SW-1:0]              slot_q;
	logic [STW-1:0]             target_q;
	logic [STW-1:0]             k_q;
	logic                       dir_up_q;
	csnm_pkg::strike_t          strike_q;
	logic                       strike_valid_q;

	// decode of the captured item
	csnm_pkg::func_t            func;
	csnm_pkg::chord_kind_t      new_kind;
	logic [SLOTS-1:0]           hit_vec;
	logic                       hit;
	logic [SW-1:0]              hit_slot;
	logic                       have_free;
	logic [SW-1:0]              free_slot;
	logic [XW:0]                y_bottom;
	logic [XW:0]                x_right;
	logic                       off_plate;
	logic                       outside_x;
	logic [STW-1:0]             nstr;
	logic [XW-1:0]              x_offset;
	logic [csnm_pkg::DVD_W-1:0] product;
	logic [XW-1:0]              divisor;
	logic                       div_start;
	csnm_pkg::div_stat_t        div_stat;
	logic [csnm_pkg::DVD_W-1:0] quotient;

	// divide result and walk step
	logic [STW-1:0]             s_clamped;
	logic [STW-1:0]             cur_last;
	logic                       cur_fresh;
	logic [STW-1:0]             next_k;
	logic                       next_in_range;
	logic                       out_free;
	logic                       walk_step;
	logic                       walk_done;
	logic                       load_out;
	logic [7:0]                 offset;
	logic [csnm_pkg::NOTE_W+1:0] note_sum;
	logic [csnm_pkg::NOTE_W-1:0] note;

	assign func = csnm_pkg::func_t'(item_q.func);

	// same-root button combination to chord kind
	always_comb begin
		if (item_q.hold_major && item_q.hold_minor && item_q.hold_seventh)
			new_kind = csnm_pkg::CK_AUG;
		else if (item_q.hold_major && item_q.hold_seventh)
			new_kind = csnm_pkg::CK_MAJ7;
		else if (item_q.hold_minor && item_q.hold_seventh)
			new_kind = csnm_pkg::CK_M7;
		else if (item_q.hold_major && item_q.hold_minor)
			new_kind = csnm_pkg::CK_DIM;
		else if (item_q.hold_seventh)
			new_kind = csnm_pkg::CK_SEVENTH;
		else if (item_q.hold_minor)
			new_kind = csnm_pkg::CK_MINOR;
		else
			new_kind = csnm_pkg::CK_MAJOR;
	end

	// slot search: owner of this finger id, else the lowest free slot
	always_comb begin
		hit_slot  = '0;
		free_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			hit_vec[i] = slot_in_use_q[i] && (slot_finger_q[i] == item_q.finger_id);
			if (hit_vec[i]) hit_slot = SW'(i);
			if (!slot_in_use_q[i]) free_slot = SW'(i);
		end
		hit       = |hit_vec;
		have_free = ~&slot_in_use_q;
	end

	// plate bounds, inclusive on both edges
	assign y_bottom  = {1'b0, plate_top_q} + {1'b0, plate_height_q};
	assign x_right   = {1'b0, plate_left_q} + {1'b0, plate_width_q};
	assign off_plate = (item_q.touch_y < plate_top_q) || ({1'b0, item_q.touch_y} > y_bottom);
	assign outside_x = (item_q.touch_x < plate_left_q) || ({1'b0, item_q.touch_x} > x_right);

	assign nstr     = csnm_pkg::string_count(chord_kind_q);
	assign x_offset = item_q.touch_x - plate_left_q;
	assign product  = csnm_pkg::DVD_W'(csnm_pkg::DVD_W'(x_offset) * csnm_pkg::DVD_W'(nstr));
	// zero width counts as one
	assign divisor  = (plate_width_q == '0) ? XW'(1) : plate_width_q;

	assign div_start = (state_q == ST_DECODE) && (func == csnm_pkg::FN_TOUCH) &&
	                   !off_plate && !outside_x && (hit || have_free);

	csnm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (divisor),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign s_clamped = (quotient > csnm_pkg::DVD_W'(nstr - 1'b1)) ? STW'(nstr - 1'b1)
	                                                               : STW'(quotient);
	assign cur_last  = slot_last_q[slot_q];
	assign cur_fresh = slot_fresh_q[slot_q];

	// one string a cycle toward the target while the output register is free; out-of-range strings pass silently
	assign next_k        = dir_up_q ? STW'(k_q + 1'b1) : STW'(k_q - 1'b1);
	assign next_in_range = next_k < nstr;
	assign out_free      = !strike_valid_q || !strike_stall;
	assign walk_step     = (state_q == ST_WALK) && (!next_in_range || out_free);
	assign load_out      = walk_step && next_in_range;
	assign walk_done     = walk_step && (next_k == target_q);

	assign offset   = csnm_pkg::string_offset(chord_kind_q, next_k);
	assign note_sum = (csnm_pkg::NOTE_W+2)'(base_note_q) + (csnm_pkg::NOTE_W+2)'(chord_root_q) +
	                  (csnm_pkg::NOTE_W+2)'(offset);
	assign note     = (note_sum > (csnm_pkg::NOTE_W+2)'(csnm_pkg::NOTE_MAX)) ?
	                  csnm_pkg::NOTE_W'(csnm_pkg::NOTE_MAX) : csnm_pkg::NOTE_W'(note_sum);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plate_left_q   <= 9'd6;
			plate_width_q  <= 9'd308;
			plate_top_q    <= 9'd18;
			plate_height_q <= 9'd102;
			base_note_q    <= 6'd36;
		end else if (wr_en) begin
			case (csnm_pkg::reg_index_t'(wr_index))
				csnm_pkg::REG_PLATE_LEFT:   plate_left_q   <= wr_data;
				csnm_pkg::REG_PLATE_WIDTH:  plate_width_q  <= wr_data;
				csnm_pkg::REG_PLATE_TOP:    plate_top_q    <= wr_data;
				csnm_pkg::REG_PLATE_HEIGHT: plate_height_q <= wr_data;
				csnm_pkg::REG_BASE_NOTE:    base_note_q    <= wr_data[csnm_pkg::BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, chord, slot occupancy and strike register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			chord_root_q   <= '0;
			chord_kind_q   <= csnm_pkg::CK_MAJOR;
			slot_in_use_q  <= '0;
			strike_valid_q <= 1'b0;
			strike_q       <= '0;
		end else begin
			// a new strike takes the register in the cycle the old one leaves
			if (load_out) strike_valid_q <= 1'b1;
			else if (strike_valid_q && !strike_stall) strike_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item_valid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					state_q <= div_start ? ST_DIVIDE : ST_IDLE;
					case (func)
						csnm_pkg::FN_CHORD: begin
							if (item_q.root <= csnm_pkg::ROOT_MAX) begin
								chord_root_q <= item_q.root;
								chord_kind_q <= new_kind;
							end
						end
						csnm_pkg::FN_LIFT: begin
							slot_in_use_q <= slot_in_use_q & ~hit_vec;
						end
						csnm_pkg::FN_TOUCH: begin
							if (off_plate) begin
								slot_in_use_q <= slot_in_use_q & ~hit_vec;
							end else if (div_start && !hit) begin
								slot_in_use_q[free_slot] <= 1'b1;
							end
						end
						default: ;
					endcase
				end
				ST_DIVIDE: begin
					if (div_stat.done) begin
						if (!cur_fresh && s_clamped == cur_last) state_q <= ST_IDLE;
						else state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (load_out) begin
						strike_q.note_number  <= note;
						strike_q.string_index <= next_k;
						strike_q.last_of_run  <= next_k == target_q;
					end
					if (walk_done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item capture, slot contents and walk position
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) item_q <= item;
		if (div_start) begin
			slot_q <= hit ? hit_slot : free_slot;
			if (!hit) begin
				slot_finger_q[free_slot] <= item_q.finger_id;
				slot_fresh_q[free_slot]  <= 1'b1;
				slot_last_q[free_slot]   <= '0;
			end
		end
		if (state_q == ST_DIVIDE && div_stat.done) begin
			target_q <= s_clamped;
			if (cur_fresh) begin
				// start one below so the first step lands on the touched string
				k_q      <= STW'(s_clamped - 1'b1);
				dir_up_q <= 1'b1;
			end else begin
				k_q      <= cur_last;
				dir_up_q <= s_clamped > cur_last;
			end
			if (!cur_fresh && s_clamped == cur_last) begin
				slot_fresh_q[slot_q] <= 1'b0;
			end
		end
		if (walk_step) k_q <= next_k;
		if (walk_done) begin
			slot_last_q[slot_q]  <= target_q;
			slot_fresh_q[slot_q] <= 1'b0;
		end
	end

	assign item_stall   = state_q != ST_IDLE;
	assign strike       = strike_q;
	assign strike_valid = strike_valid_q;

	// divider is only started when idle
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// strikes are only loaded for strings that exist on the current chord
	a_strike_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> strike_valid && (strike.string_index < nstr))
		else $error("strike beyond string count");

	// a finished run leaves its finger holding the slot
	a_run_slot_held: assert property (@(posedge clk) disable iff (!arst_n)
		walk_done |=> slot_in_use_q[slot_q] && state_q == ST_IDLE)
		else $error("finished run without its slot");

endmodule

`default_nettype wire

FILE: hw/rtl/csnm_div.sv
// restoring divider, one quotient bit per cycle, for the x to string mapping
// depends on csnm_pkg for widths and the status struct
`default_nettype none

module csnm_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [csnm_pkg::DVD_W-1:0]  dividend,
	input  wire logic [csnm_pkg::COORD_W-1:0] divisor,
	output csnm_pkg::div_stat_t              stat,
	output logic [csnm_pkg::DVD_W-1:0]       quotient
);

	localparam int CNT_W = $clog2(csnm_pkg::DVD_W + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(csnm_pkg::DVD_W - 1);

	logic [CNT_W-1:0]               cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [csnm_pkg::DVD_W-1:0]     dq_q;
	logic [csnm_pkg::COORD_W-1:0]   rem_q;
	logic [csnm_pkg::COORD_W-1:0]   dvs_q;
	logic [csnm_pkg::COORD_W:0]     trial;
	logic                           ge;

	assign trial = {rem_q, dq_q[csnm_pkg::DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? csnm_pkg::COORD_W'(trial - {1'b0, dvs_q})
			            : csnm_pkg::COORD_W'(trial);
			dq_q  <= {dq_q[csnm_pkg::DVD_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dq_q;

endmodule

`default_nettype wire
